// ----- sv/spgc_pkg.sv -----
package spgc_pkg;

  localparam int RADIUS_W   = 10;
  localparam int GAIN_W     = 16;
  localparam int COUNT_W    = 4;
  localparam int POS_W      = 13;
  localparam int COORD_W    = 11;
  localparam int CHAN_W     = 3;
  localparam int DIST_W     = 12;
  localparam int NUM_W      = 12;
  localparam int PROD_W     = NUM_W + GAIN_W;
  localparam int SQ_OP_W    = 2 * DIST_W;
  localparam int SQ_STEPS   = DIST_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int RESULT_LIMIT     = 8;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(100);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(65535);
  localparam logic [COUNT_W-1:0]  COUNT_RST  = COUNT_W'(2);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RADIUS     = 2'd0,
    CFG_MAX_GAIN   = 2'd1,
    CFG_CHAN_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic move;
    logic mul_x;
    logic mul_y;
    logic sqrt_start;
    logic dstore;
    logic gmul;
    logic div_start;
    logic emit;
    logic last;
  } spgc_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] n_use;
    logic               sqrt_done;
    logic               div_done;
    logic               s_zero;
  } spgc_sts_t;

endpackage

// ----- sv/spgc_in_if.sv -----
interface spgc_in_if;
  import spgc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [CHAN_W-1:0]       channel_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (output valid, req_type, channel_index, pos_x, pos_y, input ready);
  modport sink   (input valid, req_type, channel_index, pos_x, pos_y, output ready);
endinterface

// ----- sv/spgc_out_if.sv -----
interface spgc_out_if;
  import spgc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  out_channel;
  logic [GAIN_W-1:0]  gain;
  logic [COORD_W-1:0] stick_x_now;
  logic [COORD_W-1:0] stick_y_now;
  logic               last;

  modport source (output valid, out_channel, gain, stick_x_now, stick_y_now, last,
                  input ready);
  modport sink   (input valid, out_channel, gain, stick_x_now, stick_y_now, last,
                  output ready);
endinterface

// ----- sv/spgc_sqrt.sv -----
module spgc_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [spgc_pkg::SQ_OP_W-1:0] operand,
  output logic                         done,
  output logic [spgc_pkg::DIST_W-1:0]  root
);
  import spgc_pkg::*;

  localparam int CntW = $clog2(SQ_STEPS);

  logic [SQ_OP_W-1:0] op_r;
  logic [DIST_W:0]    rem_r;
  logic [DIST_W-1:0]  root_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIST_W+2:0]  rem_sh;
  logic [DIST_W+2:0]  trial;
  logic               fits;

  assign rem_sh = {rem_r, op_r[SQ_OP_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        op_r   <= operand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        op_r <= {op_r[SQ_OP_W-3:0], 2'b00};
        if (fits) begin
          rem_r  <= (DIST_W+1)'(rem_sh - trial);
          root_r <= {root_r[DIST_W-2:0], 1'b1};
        end else begin
          rem_r  <= (DIST_W+1)'(rem_sh);
          root_r <= {root_r[DIST_W-2:0], 1'b0};
        end
        cnt_r <= CntW'(cnt_r + 1'b1);
        if (cnt_r == CntW'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- sv/spgc_div.sv -----
module spgc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [spgc_pkg::PROD_W-1:0]  dividend,
  input  logic [spgc_pkg::COORD_W-1:0] divisor,
  output logic                         done,
  output logic [spgc_pkg::PROD_W-1:0]  quotient
);
  import spgc_pkg::*;

  localparam int CntW = $clog2(DIV_STEPS);

  logic [PROD_W-1:0]  dvd_r;
  logic [COORD_W-1:0] dvs_r;
  logic [COORD_W-1:0] rem_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [COORD_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_r, dvd_r[PROD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= COORD_W'(rem_sh - {1'b0, dvs_r});
        end else begin
          rem_r <= COORD_W'(rem_sh);
        end
        dvd_r <= {dvd_r[PROD_W-2:0], fits};
        cnt_r <= CntW'(cnt_r + 1'b1);
        if (cnt_r == CntW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- sv/spgc_datapath.sv -----
module spgc_datapath #(
  parameter int MAX_CHANNELS = spgc_pkg::MAX_CHANNELS_DEF,
  localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spgc_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [spgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [spgc_pkg::CHAN_W-1:0]     in_channel_index,
  input  logic signed [spgc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [spgc_pkg::POS_W-1:0] in_pos_y,
  input  spgc_pkg::spgc_cmd_t             cmd,
  input  logic [IdxW-1:0]                 ch,
  output spgc_pkg::spgc_sts_t             sts,
  output logic [spgc_pkg::CHAN_W-1:0]     out_channel,
  output logic [spgc_pkg::GAIN_W-1:0]     out_gain,
  output logic [spgc_pkg::COORD_W-1:0]    out_stick_x_now,
  output logic [spgc_pkg::COORD_W-1:0]    out_stick_y_now,
  output logic                            out_last
);
  import spgc_pkg::*;

  localparam int Lim = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

  logic [RADIUS_W-1:0] radius_r;
  logic [GAIN_W-1:0]   max_gain_r;
  logic [COUNT_W-1:0]  count_r;

  logic [COORD_W-1:0]  x_tab [MAX_CHANNELS];
  logic [COORD_W-1:0]  y_tab [MAX_CHANNELS];
  logic [DIST_W-1:0]   dist_r [MAX_CHANNELS];

  logic [COORD_W-1:0]  stick_x_r;
  logic [COORD_W-1:0]  stick_y_r;
  logic [COORD_W-1:0]  s_r;
  logic [PROD_W-1:0]   prod_r;

  logic [CHAN_W-1:0]   out_channel_r;
  logic [GAIN_W-1:0]   out_gain_r;
  logic [COORD_W-1:0]  out_sx_r;
  logic [COORD_W-1:0]  out_sy_r;
  logic                out_last_r;

  logic [COORD_W-1:0]  span;
  logic [COORD_W-1:0]  cx, cy, dx, dy;
  logic [DIST_W-1:0]   d;
  logic [NUM_W-1:0]    two_s, num;
  logic [NUM_W-1:0]    mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic                sqrt_done, div_done;
  logic [DIST_W-1:0]   root;
  logic [PROD_W-1:0]   quot;
  logic [GAIN_W-1:0]   gain;
  logic [IdxW-1:0]     load_idx;

  function automatic logic [COORD_W-1:0] clamp_load(input logic [POS_W-1:0] p);
    logic [COORD_W-1:0] r;
    if (p[POS_W-1]) r = '0;
    else if (p[POS_W-2]) r = '1;
    else r = p[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_span(input logic [POS_W-1:0] p,
                                                    input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] r;
    if (p[POS_W-1]) r = '0;
    else if (p[POS_W-2:0] > {1'b0, hi}) r = hi;
    else r = p[COORD_W-1:0];
    return r;
  endfunction

  assign span     = {radius_r, 1'b0};
  assign load_idx = IdxW'(in_channel_index);

  assign cx = x_tab[ch];
  assign cy = y_tab[ch];
  assign dx = (cx > stick_x_r) ? COORD_W'(cx - stick_x_r) : COORD_W'(stick_x_r - cx);
  assign dy = (cy > stick_y_r) ? COORD_W'(cy - stick_y_r) : COORD_W'(stick_y_r - cy);
  assign d  = dist_r[ch];

  assign two_s = {s_r, 1'b0};
  assign num   = (two_s > d) ? NUM_W'(two_s - d) : '0;

  always_comb begin
    priority if (cmd.gmul) begin
      mul_a = num;
      mul_b = max_gain_r;
    end else if (cmd.mul_y) begin
      mul_a = NUM_W'(dy);
      mul_b = GAIN_W'(dy);
    end else begin
      mul_a = NUM_W'(dx);
      mul_b = GAIN_W'(dx);
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (s_r == '0) begin
      gain = (d == '0) ? max_gain_r : '0;
    end else if (|quot[PROD_W-1:GAIN_W]) begin
      gain = '1;
    end else begin
      gain = quot[GAIN_W-1:0];
    end
  end

  spgc_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (SQ_OP_W'(prod_r)),
    .done    (sqrt_done),
    .root    (root)
  );

  spgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (s_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RADIUS_RST;
      max_gain_r <= GAIN_RST;
      count_r    <= COUNT_RST;
      stick_x_r  <= '0;
      stick_y_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_RADIUS:     radius_r   <= cfg_wdata[RADIUS_W-1:0];
          CFG_MAX_GAIN:   max_gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_CHAN_COUNT: count_r    <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.move) begin
        stick_x_r <= clamp_span(in_pos_x, span);
        stick_y_r <= clamp_span(in_pos_y, span);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (int'(in_channel_index) < MAX_CHANNELS)) begin
      x_tab[load_idx] <= clamp_load(in_pos_x);
      y_tab[load_idx] <= clamp_load(in_pos_y);
    end
    if (cmd.dstore) begin
      dist_r[ch] <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move) begin
      s_r <= span;
    end else if (cmd.dstore && (root < {1'b0, s_r})) begin
      s_r <= root[COORD_W-1:0];
    end
    if (cmd.mul_x || cmd.gmul) begin
      prod_r <= prod;
    end else if (cmd.mul_y) begin
      prod_r <= PROD_W'(prod_r + prod);
    end
    if (cmd.emit) begin
      out_channel_r <= CHAN_W'(ch);
      out_gain_r    <= gain;
      out_sx_r      <= stick_x_r;
      out_sy_r      <= stick_y_r;
      out_last_r    <= cmd.last;
    end
  end

  assign sts.n_use     = (count_r > COUNT_W'(Lim)) ? COUNT_W'(Lim) : count_r;
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.s_zero    = (s_r == '0);

  assign out_channel     = out_channel_r;
  assign out_gain        = out_gain_r;
  assign out_stick_x_now = out_sx_r;
  assign out_stick_y_now = out_sy_r;
  assign out_last        = out_last_r;

endmodule

// ----- sv/spgc_ctrl.sv -----
module spgc_ctrl #(
  parameter int MAX_CHANNELS = spgc_pkg::MAX_CHANNELS_DEF,
  localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spgc_pkg::spgc_sts_t sts,
  output spgc_pkg::spgc_cmd_t cmd,
  output logic [IdxW-1:0]     ch
);
  import spgc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_SQRT,
    S_SQWAIT,
    S_DSTORE,
    S_GMUL,
    S_DIV,
    S_DIVWAIT,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] ch_r, ch_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_ch;

  assign last_ch = ((5'(ch_r) + 5'd1) == 5'(sts.n_use));

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_MOVE) begin
            cmd.move = 1'b1;
            ch_nxt   = '0;
            if (sts.n_use != '0) state_nxt = S_MULX;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (sts.sqrt_done) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.dstore = 1'b1;
        if (last_ch) begin
          ch_nxt    = '0;
          state_nxt = S_GMUL;
        end else begin
          ch_nxt    = IdxW'(ch_r + 1'b1);
          state_nxt = S_MULX;
        end
      end
      S_GMUL: begin
        cmd.gmul  = 1'b1;
        state_nxt = sts.s_zero ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          cmd.last      = last_ch;
          out_valid_nxt = 1'b1;
          if (last_ch) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = IdxW'(ch_r + 1'b1);
            state_nxt = S_GMUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign ch        = ch_r;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken transfer");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sqrt_done |-> (state_r == S_SQWAIT))
    else $error("root finished outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIVWAIT))
    else $error("quotient finished outside its wait state");

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (5'(ch_r) < 5'(sts.n_use)))
    else $error("channel counter beyond channels in use");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == S_IDLE))
    else $error("no return to idle after last result");

endmodule

// ----- sv/surround_pan_gain_calc.sv -----
// Load item: no result; the next item is taken the cycle after.
// Move item: a distance for each channel in use (12-step root per channel), then a gain
// for each (28-step divide per channel); no new item is taken until the last result is
// loaded, and the gains stall while a result waits on the output register.
// Reset (rst_n, synchronous, active low) restores the register defaults and a zero
// stick; the coordinate tables hold nothing defined until loaded.
module surround_pan_gain_calc #(
  parameter int MAX_CHANNELS = spgc_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spgc_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [spgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  spgc_in_if.sink                         in_chan,
  spgc_out_if.source                      out_chan
);
  import spgc_pkg::*;

  localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  spgc_cmd_t       cmd;
  spgc_sts_t       sts;
  logic [IdxW-1:0] ch;

  spgc_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .sts         (sts),
    .cmd         (cmd),
    .ch          (ch)
  );

  spgc_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_channel_index (in_chan.channel_index),
    .in_pos_x         (in_chan.pos_x),
    .in_pos_y         (in_chan.pos_y),
    .cmd              (cmd),
    .ch               (ch),
    .sts              (sts),
    .out_channel      (out_chan.out_channel),
    .out_gain         (out_chan.gain),
    .out_stick_x_now  (out_chan.stick_x_now),
    .out_stick_y_now  (out_chan.stick_y_now),
    .out_last         (out_chan.last)
  );

endmodule

// ----- dv/surround_pan_gain_calc_test.sv -----
`timescale 1ns / 100ps

module surround_pan_gain_calc_test;
  import spgc_pkg::*;

  localparam int CHANNELS      = MAX_CHANNELS_DEF;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD     = 3000;

  typedef struct {
    logic [CHAN_W-1:0]  chan;
    logic [GAIN_W-1:0]  gain;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic               last;
  } gain_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  spgc_in_if  in_if();
  spgc_out_if out_if();

  surround_pan_gain_calc uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // shadow of the block state
  logic [COORD_W-1:0]  chan_x [CHANNELS];
  logic [COORD_W-1:0]  chan_y [CHANNELS];
  logic [COORD_W-1:0]  stick_x;
  logic [COORD_W-1:0]  stick_y;
  logic [RADIUS_W-1:0] radius_cfg;
  logic [GAIN_W-1:0]   gain_cfg;
  logic [COUNT_W-1:0]  count_cfg;

  gain_word_t expected_gains[$];
  int         fail_cnt;
  int         burst_left;
  bit         no_idle;
  bit         hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** surround_pan_gain_calc: FAILED **");
    $finish;
  end

  function automatic logic [COORD_W-1:0] clamp_coord(logic signed [POS_W-1:0] v,
                                                     int unsigned hi);
    int iv;
    iv = v;
    if (iv < 0) return '0;
    if (iv > int'(hi)) return COORD_W'(hi);
    return COORD_W'(iv);
  endfunction

  function automatic int unsigned root_floor(int unsigned n);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned stick_dist(int k);
    int dx;
    int dy;
    dx = int'(chan_x[k]) - int'(stick_x);
    dy = int'(chan_y[k]) - int'(stick_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return root_floor(dx * dx + dy * dy);
  endfunction

  function automatic void apply_item(logic req, logic [CHAN_W-1:0] idx,
                                     logic signed [POS_W-1:0] px,
                                     logic signed [POS_W-1:0] py);
    int unsigned span;
    int unsigned n;
    int unsigned s;
    int unsigned num;
    longint unsigned g;
    int unsigned d [CHANNELS];
    gain_word_t w;
    span = 2 * radius_cfg;
    if (req == REQ_LOAD) begin
      chan_x[idx] = clamp_coord(px, 2047);
      chan_y[idx] = clamp_coord(py, 2047);
    end else begin
      stick_x = clamp_coord(px, span);
      stick_y = clamp_coord(py, span);
      n = (count_cfg > CHANNELS) ? CHANNELS : count_cfg;
      s = span;
      for (int k = 0; k < n; k++) begin
        d[k] = stick_dist(k);
        if (d[k] < s) s = d[k];
      end
      for (int k = 0; k < n; k++) begin
        if (s == 0) begin
          g = (d[k] == 0) ? gain_cfg : 0;
        end else begin
          num = (2 * s > d[k]) ? 2 * s - d[k] : 0;
          g = (longint'(num) * gain_cfg) / s;
          if (g > 16'hFFFF) g = 16'hFFFF;
        end
        w.chan = CHAN_W'(k);
        w.gain = GAIN_W'(g);
        w.sx   = stick_x;
        w.sy   = stick_y;
        w.last = (k + 1 == n);
        expected_gains.push_back(w);
      end
    end
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos(int lo, int hi);
    return POS_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    gain_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_gains.size() == 0) begin
        $error("unexpected transfer: channel %0d gain %0d", out_if.out_channel, out_if.gain);
        fail_cnt++;
      end else begin
        w = expected_gains.pop_front();
        check_field("out_channel", w.chan, out_if.out_channel);
        check_field("gain", w.gain, out_if.gain);
        check_field("stick_x_now", w.sx, out_if.stick_x_now);
        check_field("stick_y_now", w.sy, out_if.stick_y_now);
        check_field("last", w.last, out_if.last);
      end
    end
  end

  // receiver: own stall pattern, plus a long hold on request
  initial begin
    int hold_cnt;
    int run_left;
    int stall_left;
    hold_cnt   = 0;
    run_left   = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt--;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else if (run_left > 0) begin
        out_if.ready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        run_left   = $urandom_range(0, 12);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic req, input logic [CHAN_W-1:0] idx,
                           input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] py);
    int gap;
    if (!no_idle && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid         <= 1'b1;
    in_if.req_type      <= req;
    in_if.channel_index <= idx;
    in_if.pos_x         <= px;
    in_if.pos_y         <= py;
    do @(posedge clk); while (!in_if.ready);
    apply_item(req, idx, px, py);
  endtask

  // sender stops and waits for every expected result
  task automatic go_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_gains.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned r, input int unsigned g,
                            input int unsigned c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RADIUS;
    cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    radius_cfg = RADIUS_W'(r);
    cfg_index <= CFG_MAX_GAIN;
    cfg_wdata <= CFG_DATA_W'(g);
    @(posedge clk);
    gain_cfg = GAIN_W'(g);
    cfg_index <= CFG_CHAN_COUNT;
    cfg_wdata <= CFG_DATA_W'(c);
    @(posedge clk);
    count_cfg = COUNT_W'(c);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(REQ_LOAD, 0, 50, 50);
    send_item(REQ_LOAD, 1, 150, 150);
    send_item(REQ_MOVE, 5, 100, 100);
    send_item(REQ_MOVE, 2, -5, 300);
  endtask

  task automatic test_load_all();
    send_item(REQ_LOAD, 0, -4096, 4095);
    send_item(REQ_LOAD, 1, 4095, -4096);
    send_item(REQ_LOAD, 2, 0, 0);
    send_item(REQ_LOAD, 3, 2047, 2047);
    send_item(REQ_LOAD, 4, 2048, -1);
    send_item(REQ_LOAD, 5, 1000, 1000);
    send_item(REQ_LOAD, 6, 1000, 1000);
    send_item(REQ_LOAD, 7, -1, 2048);
  endtask

  task automatic test_extremes();
    go_idle();
    set_config(1023, 65535, 8);
    send_item(REQ_MOVE, 0, 0, 0);
    send_item(REQ_MOVE, 7, 4095, 4095);
    send_item(REQ_MOVE, 3, 1000, 1000);
    send_item(REQ_MOVE, 1, -4096, -4096);
    send_item(REQ_MOVE, 6, 2046, 0);
    go_idle();
    // zero radius pins the stick at the origin
    set_config(0, 0, 15);
    send_item(REQ_MOVE, 4, 123, -7);
    go_idle();
    set_config(0, 65535, 8);
    send_item(REQ_MOVE, 2, 4095, 4095);
    go_idle();
    // shortest distance capped at the span
    set_config(1, 1, 1);
    send_item(REQ_MOVE, 0, 2, 2);
    go_idle();
    set_config(512, 12345, 0);
    send_item(REQ_MOVE, 0, 700, 300);
    send_item(REQ_MOVE, 1, 10, 20);
    go_idle();
    set_config(512, 12345, 3);
    send_item(REQ_MOVE, 0, 300, 700);
  endtask

  task automatic test_backpressure();
    go_idle();
    set_config(300, 40000, 8);
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++)
      send_item(REQ_MOVE, CHAN_W'(k), rand_pos(-10, 610), rand_pos(-10, 610));
  endtask

  task automatic test_drain_pause();
    send_item(REQ_MOVE, 0, 250, 250);
    send_item(REQ_MOVE, 0, 600, 0);
    go_idle();
    send_item(REQ_MOVE, 0, 0, 600);
    send_item(REQ_LOAD, 3, 300, 300);
    send_item(REQ_MOVE, 0, 300, 300);
  endtask

  task automatic test_random(input int n_items);
    int unsigned span;
    int unsigned r;
    int unsigned g;
    int unsigned c;
    int pick;
    int k;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) begin
        go_idle();
        case ($urandom_range(0, 5))
          0:       r = 1;
          1:       r = 1023;
          2:       r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          default: r = $urandom_range(1, 1023);
        endcase
        case ($urandom_range(0, 5))
          0:       g = 0;
          1:       g = 65535;
          default: g = $urandom_range(0, 65535);
        endcase
        c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        set_config(r, g, c);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      span = 2 * radius_cfg;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, CHANNELS - 1);
      if (pick < 25) begin
        if ($urandom_range(0, 4) == 0)
          send_item(REQ_LOAD, CHAN_W'(k), rand_pos(-4096, 4095), rand_pos(-4096, 4095));
        else
          send_item(REQ_LOAD, CHAN_W'(k), rand_pos(0, span), rand_pos(0, span));
      end else if (pick < 45) begin
        send_item(REQ_MOVE, CHAN_W'($urandom), POS_W'(chan_x[k]), POS_W'(chan_y[k]));
      end else if (pick < 90) begin
        send_item(REQ_MOVE, CHAN_W'($urandom), rand_pos(-20, span + 20),
                  rand_pos(-20, span + 20));
      end else begin
        send_item(REQ_MOVE, CHAN_W'($urandom), rand_pos(-4096, 4095),
                  rand_pos(-4096, 4095));
      end
    end
  endtask

  initial begin
    fail_cnt   = 0;
    burst_left = 0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    radius_cfg = RADIUS_RST;
    gain_cfg   = GAIN_RST;
    count_cfg  = COUNT_RST;
    stick_x    = '0;
    stick_y    = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      chan_x[k] = '0;
      chan_y[k] = '0;
    end
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_RADIUS;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.req_type      <= REQ_LOAD;
    in_if.channel_index <= '0;
    in_if.pos_x         <= '0;
    in_if.pos_y         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_load_all();
    test_extremes();
    test_backpressure();
    test_drain_pause();
    test_random(165);
    go_idle();

    if (fail_cnt == 0)
      $display("** surround_pan_gain_calc: PASSED **");
    else
      $display("** surround_pan_gain_calc: FAILED **");
    $finish;
  end

endmodule
